// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the RTL (used by ssm_tail). Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising edge of clk, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Types and constants of the sorted set membership unit.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 1024;
  localparam int unsigned VALUE_W          = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // item travelling down the chain of cells
  typedef struct packed {
    logic                       valid;
    cmd_e                       cmd;
    logic signed [VALUE_W-1:0]  value;
    logic                       found;
  } item_t;

endpackage

// ----- rtl/ssm_cell.sv -----
// ----------------------------------------------------------------------------
// ssm_cell
// One storage cell of the chain: holds one value and forwards the item.
// ----------------------------------------------------------------------------
module ssm_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  ssm_pkg::item_t item_in,
  output ssm_pkg::item_t item_out
);
  import ssm_pkg::*;

  logic                      occ_r;
  logic                      occ_nxt;
  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] val_nxt;
  item_t                     item_r;
  item_t                     item_nxt;

  always_comb begin
    occ_nxt  = occ_r;
    val_nxt  = val_r;
    item_nxt = item_in;
    if (item_in.valid) begin
      unique case (item_in.cmd)
        CMD_CLEAR: begin
          occ_nxt = 1'b0;
        end
        CMD_INSERT: begin
          // first empty cell takes the value and consumes the item
          if (!occ_r) begin
            occ_nxt        = 1'b1;
            val_nxt        = item_in.value;
            item_nxt.valid = 1'b0;
          end
        end
        CMD_QUERY: begin
          item_nxt.found = item_in.found | (occ_r && (val_r == item_in.value));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      item_r <= '0;
    end else if (adv) begin
      occ_r  <= occ_nxt;
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= val_nxt;
    end
  end

  assign item_out = item_r;

endmodule

// ----- rtl/ssm_tail.sv -----
// ----------------------------------------------------------------------------
// ssm_tail
// End of the chain: sticky overflow flag and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssm_tail (
  input  logic           clk,
  input  logic           rst_n,
  input  ssm_pkg::item_t item_in,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_found,
  output logic           out_overflowed
);
  import ssm_pkg::*;

  logic ovf_r;
  logic ovf_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic found_r;
  logic found_nxt;
  logic oflow_r;
  logic oflow_nxt;

  // chain stalls only when a query must load a still-occupied result register
  assign adv = !(item_in.valid && (item_in.cmd == CMD_QUERY) && out_valid_r && !out_ready);

  always_comb begin
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    oflow_nxt     = oflow_r;
    if (adv && item_in.valid) begin
      unique case (item_in.cmd)
        CMD_CLEAR: begin
          ovf_nxt = 1'b0;
        end
        CMD_INSERT: begin
          // an insert that got here found no free cell
          ovf_nxt = 1'b1;
        end
        CMD_QUERY: begin
          out_valid_nxt = 1'b1;
          found_nxt     = item_in.found;
          oflow_nxt     = ovf_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    oflow_r <= oflow_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_overflowed = oflow_r;

  `ASSERT_CLK(a_clear_drops_ovf,
    (adv && item_in.valid && item_in.cmd == CMD_CLEAR) |=> !ovf_r,
    "overflow flag survived a clear")
  `ASSERT_CLK(a_drop_sets_ovf,
    (adv && item_in.valid && item_in.cmd == CMD_INSERT) |=> ovf_r,
    "dropped insert did not raise overflow")
  `ASSERT_CLK(a_query_loads_result,
    (adv && item_in.valid && item_in.cmd == CMD_QUERY) |=> out_valid_r,
    "query left the chain without a result")
  `ASSERT_CLK(a_stall_only_when_full,
    !adv |-> (out_valid_r && !out_ready),
    "chain stalled with a free result register")

endmodule

// ----- rtl/sorted_set_membership_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_set_membership_unit
// Set of signed 32-bit values with clear, insert and membership query.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries in_command (clear, insert, query)
// and in_value. Command three is accepted and discarded.
// Each item walks down a chain of CAPACITY cells, one cell per cycle unless
// the chain stalls; every cell holds one value. An insert lands in the first
// empty cell, a clear empties each cell it passes, a query collects the
// equality hits. At the end of the chain a sticky overflow flag catches
// inserts that found no free cell; a clear lowers it.
// Only a query gives a result on out_valid/out_ready: out_found and
// out_overflowed. One item is accepted per cycle while the chain is not
// stalled, since all items move in lockstep.
// If the receiver stalls while a result waits, the whole chain freezes only
// when the next query reaches the end; in_ready then drops.
// Synchronous reset empties every cell, clears the flag and drops out_valid.
// ----------------------------------------------------------------------------
module sorted_set_membership_unit #(
  parameter int unsigned CAPACITY = ssm_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic signed [ssm_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic                                out_overflowed
);
  import ssm_pkg::*;

  item_t chain [CAPACITY+1];
  item_t head;
  logic  adv;
  logic  cmd_known;

  assign cmd_known = (in_command == CMD_CLEAR) || (in_command == CMD_INSERT) ||
                     (in_command == CMD_QUERY);

  assign in_ready = adv;

  always_comb begin
    head.valid = in_valid && adv && cmd_known;
    head.cmd   = cmd_e'(in_command);
    head.value = in_value;
    head.found = 1'b0;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .item_in  (chain[i]),
      .item_out (chain[i+1])
    );
  end

  ssm_tail u_tail (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_in        (chain[CAPACITY]),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_overflowed (out_overflowed)
  );

endmodule
